// ===== rtl/vna_pkg.sv =====
// shared types, constants and helpers for the vertex normal accumulator
`timescale 1ns / 1ps

package vna_pkg;

  localparam int DEF_MAX_VERTICES = 1024;

  localparam int IDX_W   = 10;
  localparam int POS_W   = 16;
  localparam int DIFF_W  = 17;
  localparam int SUM_W   = 26;
  localparam int CNT_W   = 10;
  localparam int ID_W    = 16;
  localparam int NORM_W  = 16;
  localparam int CROSS_W = 35;
  localparam int MAG_W   = 34;
  localparam int SQM_W   = 30;
  localparam int OPND_W  = 31;
  localparam int PROD_W  = 62;
  localparam int SS_W    = 62;
  localparam int LEN_W   = 31;
  localparam int FRAC_W  = 14;
  localparam int DIVN_W  = LEN_W + FRAC_W;
  localparam int QUO_W   = 15;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(1023);
  localparam logic [QUO_W-1:0] Q_ONE     = QUO_W'(16384);

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [NORM_W-1:0] norm_t;

  localparam sum_t  SUM_MAX  = sum_t'(33554431);
  localparam sum_t  SUM_MIN  = sum_t'(-33554432);
  localparam norm_t NORM_MAX = norm_t'(16384);
  localparam norm_t NORM_MIN = norm_t'(-16384);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FACE = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic KIND_FACE   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    sum_t             sz;
    sum_t             sy;
    sum_t             sx;
  } sum_entry_t;

  // control from the sequencer to the normal unit
  typedef struct packed {
    logic start;
    logic face;
  } nu_req_t;

  typedef struct packed {
    logic done;
    logic degen;
  } nu_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_FETCH_C,
    ST_FETCH_END,
    ST_FACE_GO,
    ST_CALC,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_SUM_RD,
    ST_SUM_CHK,
    ST_EMIT
  } vna_state_t;

  typedef enum logic [3:0] {
    NU_IDLE,
    NU_MUL_CROSS,
    NU_ABS,
    NU_SHIFT,
    NU_MUL_SQ,
    NU_SQRT,
    NU_DIV_INIT,
    NU_DIV,
    NU_DONE
  } nu_state_t;

  function automatic sum_t sat_add(sum_t a, norm_t b);
    logic signed [SUM_W:0] r;
    r = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (r > (SUM_W+1)'(SUM_MAX)) begin
      return SUM_MAX;
    end else if (r < (SUM_W+1)'(SUM_MIN)) begin
      return SUM_MIN;
    end
    return SUM_W'(r);
  endfunction

endpackage

// ===== rtl/vna_nunit.sv =====
// shared normal unit: cross product, magnitude scaling, square root and division
`timescale 1ns / 1ps

module vna_nunit import vna_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  nu_req_t req,
  input  diff_t   u [3],
  input  diff_t   v [3],
  input  sum_t    s [3],
  output nu_rsp_t rsp,
  output norm_t   n [3]
);

  nu_state_t state, state_next;

  logic [2:0]               k;
  diff_t                    ur [3];
  diff_t                    vr [3];
  logic signed [CROSS_W-1:0] c [3];
  logic [MAG_W-1:0]         m [3];
  logic                     neg [3];
  logic signed [PROD_W-1:0] prod;
  logic signed [OPND_W-1:0] ma, mb;
  logic [SS_W-1:0]          ss;
  logic [SS_W-1:0]          rem, res, sbit;
  logic [SS_W:0]            trial;
  logic                     take;
  logic [LEN_W-1:0]         len;
  logic [DIVN_W-1:0]        num, dsh;
  logic [QUO_W-1:0]         quo, quo_next, qsat;
  logic                     dtake;
  logic [1:0]               j;
  logic [3:0]               step;
  logic                     degen;
  logic                     need_shift;
  logic [1:0]               ci;

  // operand selection for the single multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == NU_MUL_SQ) begin
      ma = $signed({1'b0, m[k[1:0] == 2'd3 ? 0 : k[1:0]][SQM_W-1:0]});
      mb = ma;
    end else begin
      case (k)
        3'd0: begin ma = OPND_W'(ur[1]); mb = OPND_W'(vr[2]); end
        3'd1: begin ma = OPND_W'(ur[2]); mb = OPND_W'(vr[1]); end
        3'd2: begin ma = OPND_W'(ur[2]); mb = OPND_W'(vr[0]); end
        3'd3: begin ma = OPND_W'(ur[0]); mb = OPND_W'(vr[2]); end
        3'd4: begin ma = OPND_W'(ur[0]); mb = OPND_W'(vr[1]); end
        3'd5: begin ma = OPND_W'(ur[1]); mb = OPND_W'(vr[0]); end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end

  assign need_shift = (m[0][MAG_W-1:SQM_W] != '0) || (m[1][MAG_W-1:SQM_W] != '0) ||
                      (m[2][MAG_W-1:SQM_W] != '0);
  assign trial    = {1'b0, res} + {1'b0, sbit};
  assign take     = {1'b0, rem} >= trial;
  assign dtake    = num >= dsh;
  assign quo_next = {quo[QUO_W-2:0], dtake};
  assign qsat     = (quo_next > Q_ONE) ? Q_ONE : quo_next;
  assign ci       = 2'((k - 3'd1) >> 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      NU_IDLE:      if (req.start) state_next = req.face ? NU_MUL_CROSS : NU_ABS;
      NU_MUL_CROSS: if (k == 3'd6) state_next = NU_ABS;
      NU_ABS:       state_next = NU_SHIFT;
      NU_SHIFT:     if (!need_shift) state_next = NU_MUL_SQ;
      NU_MUL_SQ:    if (k == 3'd3) state_next = NU_SQRT;
      NU_SQRT:      if (sbit[0]) state_next = NU_DIV_INIT;
      NU_DIV_INIT:  state_next = (len == '0) ? NU_DONE : NU_DIV;
      NU_DIV:       if (step == 4'd14) state_next = (j == 2'd2) ? NU_DONE : NU_DIV_INIT;
      NU_DONE:      state_next = NU_IDLE;
      default:      state_next = NU_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done  = (state == NU_DONE);
    rsp.degen = degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= NU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (state)
      NU_IDLE: begin
        k <= '0;
        for (int i = 0; i < 3; i++) begin
          ur[i] <= u[i];
          vr[i] <= v[i];
          c[i]  <= CROSS_W'(s[i]);
        end
        // the last normal stays valid until the next start
        if (req.start) begin
          degen <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            n[i] <= '0;
          end
        end
      end
      NU_MUL_CROSS: begin
        k <= k + 3'd1;
        if (k != 3'd0) begin
          // odd steps load the first product of each component, even steps subtract the second
          if (k[0]) begin
            c[ci] <= CROSS_W'(prod);
          end else begin
            c[ci] <= c[ci] - CROSS_W'(prod);
          end
        end
      end
      NU_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= c[i][CROSS_W-1];
          m[i]   <= c[i][CROSS_W-1] ? MAG_W'(-c[i]) : MAG_W'(c[i]);
        end
        k <= '0;
      end
      NU_SHIFT: begin
        if (need_shift) begin
          for (int i = 0; i < 3; i++) begin
            m[i] <= m[i] >> 1;
          end
        end
        k  <= '0;
        ss <= '0;
      end
      NU_MUL_SQ: begin
        k <= k + 3'd1;
        if (k != 3'd0) begin
          ss <= ss + SS_W'(prod);
        end
        if (k == 3'd3) begin
          rem  <= ss + SS_W'(prod);
          res  <= '0;
          sbit <= SS_W'(1) << (SS_W - 2);
        end
      end
      NU_SQRT: begin
        if (take) begin
          rem <= rem - trial[SS_W-1:0];
          res <= (res >> 1) + sbit;
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
        if (sbit[0]) begin
          len <= take ? LEN_W'((res >> 1) + sbit) : LEN_W'(res >> 1);
        end
        j <= '0;
      end
      NU_DIV_INIT: begin
        num   <= {m[j][SQM_W-1:0], FRAC_W'(0)} + DIVN_W'(len >> 1);
        dsh   <= {len, FRAC_W'(0)};
        quo   <= '0;
        step  <= '0;
        if (len == '0) degen <= 1'b1;
      end
      NU_DIV: begin
        if (dtake) num <= num - dsh;
        dsh  <= dsh >> 1;
        quo  <= quo_next;
        step <= step + 4'd1;
        if (step == 4'd14) begin
          n[j] <= neg[j] ? -NORM_W'(qsat) : NORM_W'(qsat);
          j    <= j + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/vertex_normal_accumulator.sv =====
// Vertex normal accumulator: vertex table with per-vertex normal sums and a
// shared normal unit. A face reads its three corner positions, forms the
// cross product and unit normal on the single multiplier / compare-subtract
// unit (cross product, scaling, squares, square-root steps and a division
// per component), then updates each corner's sum with a read and a write.
// A read normalises the vertex's sum on the same unit, or skips the unit
// when the vertex has no faces. After reset a clearing pass runs over the
// sum table, one entry a cycle over min(MAX_VERTICES, 1024) entries, before
// the first item is taken.
`timescale 1ns / 1ps

module vertex_normal_accumulator import vna_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [IDX_W-1:0]  vertex_index,
  input  pos_t              pos_x,
  input  pos_t              pos_y,
  input  pos_t              pos_z,
  input  logic [IDX_W-1:0]  corner_a,
  input  logic [IDX_W-1:0]  corner_b,
  input  logic [IDX_W-1:0]  corner_c,
  input  logic [IDX_W-1:0]  corner_d,
  input  logic              four_sided,
  input  logic [ID_W-1:0]   face_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [ID_W-1:0]   item_id,
  output norm_t             norm_x,
  output norm_t             norm_y,
  output norm_t             norm_z,
  output logic              degenerate
);

  localparam int DEPTH = (MAX_VERTICES < (1 << IDX_W)) ? MAX_VERTICES : (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);

  vna_state_t state, state_next;

  logic [3*POS_W-1:0] pos_mem [DEPTH];
  sum_entry_t         sum_mem [DEPTH];
  logic [3*POS_W-1:0] pos_rd;
  sum_entry_t         sum_rd;

  logic [AW-1:0]      clr_addr;
  logic               in_acc;

  op_t                op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   crn [4];
  logic               rng [4];
  logic               rng_idx;
  logic               quad_r;
  logic [ID_W-1:0]    fid_r;
  logic               force_zero;
  logic [1:0]         acc_k;
  logic               acc_last;

  pos_t               pa [3];
  pos_t               pb [3];
  pos_t               pc [3];

  // memory controls
  logic               pos_we, sum_we;
  logic [AW-1:0]      pos_addr, sum_addr;
  sum_entry_t         sum_wd;

  nu_req_t            nu_req;
  nu_rsp_t            nu_rsp;
  diff_t              fu [3];
  diff_t              fv [3];
  sum_t               vs [3];
  norm_t              nu_n [3];

  logic               in_rng_idx;
  logic               in_rng [4];
  logic               out_free;

  assign in_acc     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign in_rng_idx = 32'(vertex_index) < 32'(MAX_VERTICES);
  assign in_rng[0]  = 32'(corner_a) < 32'(MAX_VERTICES);
  assign in_rng[1]  = 32'(corner_b) < 32'(MAX_VERTICES);
  assign in_rng[2]  = 32'(corner_c) < 32'(MAX_VERTICES);
  assign in_rng[3]  = 32'(corner_d) < 32'(MAX_VERTICES);
  assign acc_last   = (acc_k == (quad_r ? 2'd3 : 2'd2));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fu[i] = DIFF_W'(pb[i]) - DIFF_W'(pa[i]);
      fv[i] = DIFF_W'(pc[i]) - DIFF_W'(pb[i]);
    end
    vs[0] = sum_rd.sx;
    vs[1] = sum_rd.sy;
    vs[2] = sum_rd.sz;
  end

  vna_nunit u_nunit (
    .clk (clk),
    .rst (rst),
    .req (nu_req),
    .u   (fu),
    .v   (fv),
    .s   (vs),
    .rsp (nu_rsp),
    .n   (nu_n)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (op_t'(op))
            OP_FACE: state_next = ST_FETCH_A;
            OP_READ: state_next = ST_SUM_RD;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_FETCH_A:   state_next = ST_FETCH_B;
      ST_FETCH_B:   state_next = ST_FETCH_C;
      ST_FETCH_C:   state_next = ST_FETCH_END;
      ST_FETCH_END: state_next = ST_FACE_GO;
      ST_FACE_GO:   state_next = ST_CALC;
      ST_CALC: begin
        if (nu_rsp.done) state_next = (op_r == OP_FACE) ? ST_ACC_RD : ST_EMIT;
      end
      ST_ACC_RD:    state_next = ST_ACC_WR;
      ST_ACC_WR:    state_next = acc_last ? ST_EMIT : ST_ACC_RD;
      ST_SUM_RD:    state_next = ST_SUM_CHK;
      ST_SUM_CHK: begin
        state_next = (!rng_idx || sum_rd.cnt == '0) ? ST_EMIT : ST_CALC;
      end
      ST_EMIT:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready   = (state == ST_IDLE);
    pos_we     = 1'b0;
    sum_we     = 1'b0;
    pos_addr   = AW'(vertex_index);
    sum_addr   = AW'(vertex_index);
    sum_wd     = '0;
    nu_req     = '0;
    case (state)
      ST_CLEAR: begin
        sum_we   = 1'b1;
        sum_addr = clr_addr;
      end
      ST_IDLE: begin
        pos_we = in_acc && (op_t'(op) == OP_LOAD) && in_rng_idx;
        sum_we = pos_we;
      end
      ST_FETCH_A: pos_addr = AW'(crn[0]);
      ST_FETCH_B: pos_addr = AW'(crn[1]);
      ST_FETCH_C: pos_addr = AW'(crn[2]);
      ST_FACE_GO: begin
        nu_req.start = 1'b1;
        nu_req.face  = 1'b1;
      end
      ST_ACC_RD:  sum_addr = AW'(crn[acc_k]);
      ST_ACC_WR: begin
        sum_addr  = AW'(crn[acc_k]);
        sum_we    = rng[acc_k];
        sum_wd.sx = sat_add(sum_rd.sx, nu_n[0]);
        sum_wd.sy = sat_add(sum_rd.sy, nu_n[1]);
        sum_wd.sz = sat_add(sum_rd.sz, nu_n[2]);
        sum_wd.cnt = (sum_rd.cnt == COUNT_MAX) ? sum_rd.cnt : sum_rd.cnt + CNT_W'(1);
      end
      ST_SUM_RD:  sum_addr = AW'(idx_r);
      ST_SUM_CHK: begin
        sum_addr     = AW'(idx_r);
        nu_req.start = rng_idx && (sum_rd.cnt != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_addr] <= {pos_z, pos_y, pos_x};
    pos_rd <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_addr] <= sum_wd;
    sum_rd <= sum_mem[sum_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // transaction capture and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= op_t'(op);
      idx_r   <= vertex_index;
      rng_idx <= in_rng_idx;
      crn[0]  <= corner_a;
      crn[1]  <= corner_b;
      crn[2]  <= corner_c;
      crn[3]  <= corner_d;
      for (int i = 0; i < 4; i++) rng[i] <= in_rng[i];
      quad_r  <= four_sided;
      fid_r   <= face_id;
      acc_k   <= '0;
    end
    // out of range corners read as the origin
    if (state == ST_FETCH_B) begin
      for (int i = 0; i < 3; i++) pa[i] <= rng[0] ? pos_t'(pos_rd[i*POS_W +: POS_W]) : '0;
    end
    if (state == ST_FETCH_C) begin
      for (int i = 0; i < 3; i++) pb[i] <= rng[1] ? pos_t'(pos_rd[i*POS_W +: POS_W]) : '0;
    end
    if (state == ST_FETCH_END) begin
      for (int i = 0; i < 3; i++) pc[i] <= rng[2] ? pos_t'(pos_rd[i*POS_W +: POS_W]) : '0;
    end
    if (state == ST_ACC_WR) acc_k <= acc_k + 2'd1;
    if (state == ST_FACE_GO) force_zero <= 1'b0;
    if (state == ST_SUM_CHK) force_zero <= !rng_idx || (sum_rd.cnt == '0);
    if (state == ST_EMIT && out_free) begin
      if (op_r == OP_FACE) begin
        kind    <= KIND_FACE;
        item_id <= fid_r;
      end else begin
        kind    <= KIND_VERTEX;
        item_id <= ID_W'(idx_r);
      end
      norm_x     <= force_zero ? '0 : nu_n[0];
      norm_y     <= force_zero ? '0 : nu_n[1];
      norm_z     <= force_zero ? '0 : nu_n[2];
      degenerate <= force_zero || nu_rsp.degen;
    end
  end

`ifndef ASSERT_OFF
  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    nu_rsp.done |-> state == ST_CALC)
    else $error("normal unit finished outside calc");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    nu_rsp.done && !nu_rsp.degen |->
      nu_n[0] <= NORM_MAX && nu_n[0] >= NORM_MIN &&
      nu_n[1] <= NORM_MAX && nu_n[1] >= NORM_MIN &&
      nu_n[2] <= NORM_MAX && nu_n[2] >= NORM_MIN)
    else $error("normal component beyond unit range");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
    else $error("degenerate result with non-zero normal");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    nu_req.start |=> !in_ready)
    else $error("transaction taken while normal unit busy");
`endif

endmodule

// ===== verif/vertex_normal_accumulator_tb.sv =====
// self-checking testbench for the vertex normal accumulator
`timescale 1ns / 1ps

module vertex_normal_accumulator_tb import vna_pkg::*;;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int TAIL_CYCLES    = 250;
  localparam int HOLD_CYCLES    = 400;
  localparam int N_RANDOM       = 630;

  typedef struct {
    op_t              op;
    logic [IDX_W-1:0] vi;
    pos_t             px, py, pz;
    logic [IDX_W-1:0] ca, cb, cc, cd;
    logic             quad;
    logic [ID_W-1:0]  fid;
    bit               drain;
  } stim_t;

  typedef struct {
    logic            kind;
    logic [ID_W-1:0] id;
    norm_t           nx, ny, nz;
    logic            degen;
  } normal_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = '0;
  logic [IDX_W-1:0] vertex_index = '0;
  pos_t pos_x = '0, pos_y = '0, pos_z = '0;
  logic [IDX_W-1:0] corner_a = '0, corner_b = '0, corner_c = '0, corner_d = '0;
  logic four_sided = 1'b0;
  logic [ID_W-1:0] face_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic [ID_W-1:0] item_id;
  norm_t norm_x, norm_y, norm_z;
  logic degenerate;

  vertex_normal_accumulator DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  longint pos_tab [1024][3];
  longint sum_tab [1024][3];
  int     cnt_tab [1024];

  stim_t       pending_items[$];
  normal_res_t expected_normals[$];
  int          loaded[$];
  int          accepted = 0;
  int          results  = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic normal_res_t unit_normal(longint c[3]);
    longint unsigned m[3], mx, ss, len, q;
    bit neg[3];
    normal_res_t r;
    longint n[3];
    mx = 0;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      m[i] = neg[i] ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    for (int i = 0; i < 3; i++) ss += m[i] * m[i];
    len = int_sqrt(ss);
    r.degen = (len == 0);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        n[i] = 0;
      end else begin
        q = (m[i] * 16384 + len / 2) / len;
        if (q > 16384) q = 16384;
        n[i] = neg[i] ? -longint'(q) : longint'(q);
      end
    end
    r.nx = norm_t'(n[0]);
    r.ny = norm_t'(n[1]);
    r.nz = norm_t'(n[2]);
    return r;
  endfunction

  function automatic void add_to_vertex(int idx, normal_res_t r);
    longint v[3];
    longint s;
    v[0] = r.nx;
    v[1] = r.ny;
    v[2] = r.nz;
    for (int i = 0; i < 3; i++) begin
      s = sum_tab[idx][i] + v[i];
      if (s > 33554431) s = 33554431;
      if (s < -33554432) s = -33554432;
      sum_tab[idx][i] = s;
    end
    if (cnt_tab[idx] < 1023) cnt_tab[idx]++;
  endfunction

  // work out the result of one accepted transaction
  function automatic void predict_normal(stim_t s);
    normal_res_t r;
    longint u[3], v[3], c[3];
    case (s.op)
      OP_LOAD: begin
        pos_tab[s.vi][0] = s.px;
        pos_tab[s.vi][1] = s.py;
        pos_tab[s.vi][2] = s.pz;
        for (int i = 0; i < 3; i++) sum_tab[s.vi][i] = 0;
        cnt_tab[s.vi] = 0;
      end
      OP_FACE: begin
        for (int i = 0; i < 3; i++) begin
          u[i] = pos_tab[s.cb][i] - pos_tab[s.ca][i];
          v[i] = pos_tab[s.cc][i] - pos_tab[s.cb][i];
        end
        c[0] = u[1] * v[2] - u[2] * v[1];
        c[1] = u[2] * v[0] - u[0] * v[2];
        c[2] = u[0] * v[1] - u[1] * v[0];
        r = unit_normal(c);
        add_to_vertex(s.ca, r);
        add_to_vertex(s.cb, r);
        add_to_vertex(s.cc, r);
        if (s.quad) add_to_vertex(s.cd, r);
        r.kind = KIND_FACE;
        r.id = s.fid;
        expected_normals.push_back(r);
      end
      OP_READ: begin
        if (cnt_tab[s.vi] == 0) begin
          r = '{kind: KIND_VERTEX, id: '0, nx: '0, ny: '0, nz: '0, degen: 1'b1};
        end else begin
          r = unit_normal(sum_tab[s.vi]);
          r.kind = KIND_VERTEX;
        end
        r.id = ID_W'(s.vi);
        expected_normals.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // driver
  stim_t shown, nxt;
  bit    have_nxt = 0;
  int    gap = 0;
  always @(posedge clk) begin
    logic vld_n;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      vld_n = in_valid;
      if (in_valid && in_ready) begin
        predict_normal(shown);
        accepted++;
        vld_n = 1'b0;
      end
      if (!have_nxt && pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        have_nxt = 1;
        gap = ((accepted / 60) % 3 == 1) ? 0 : $urandom_range(0, 10);
      end
      if (!vld_n && have_nxt) begin
        if (gap > 0) begin
          gap--;
        end else if (!nxt.drain || expected_normals.size() == 0) begin
          shown = nxt;
          have_nxt = 0;
          vld_n = 1'b1;
          op <= nxt.op;
          vertex_index <= nxt.vi;
          pos_x <= nxt.px;
          pos_y <= nxt.py;
          pos_z <= nxt.pz;
          corner_a <= nxt.ca;
          corner_b <= nxt.cb;
          corner_c <= nxt.cc;
          corner_d <= nxt.cd;
          four_sided <= nxt.quad;
          face_id <= nxt.fid;
        end
      end
      in_valid <= vld_n;
    end
  end

  // monitor and receiver stalls
  int  rx_wait = 0;
  int  hold = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    normal_res_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results++;
        if (expected_normals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result id %0d", item_id);
        end else begin
          e = expected_normals.pop_front();
          if (kind !== e.kind || item_id !== e.id || norm_x !== e.nx || norm_y !== e.ny ||
              norm_z !== e.nz || degenerate !== e.degen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp k%0d id%0d (%0d,%0d,%0d) d%0d got k%0d id%0d (%0d,%0d,%0d) d%0d",
                       e.kind, e.id, e.nx, e.ny, e.nz, e.degen,
                       kind, item_id, norm_x, norm_y, norm_z, degenerate);
          end
        end
        rx_wait = ((results / 50) % 3 == 2) ? 0 : $urandom_range(0, 10);
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && accepted >= 300) begin
        hold_done = 1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic stim_t base_item(op_t o);
    stim_t s;
    s.op = o;
    s.vi = IDX_W'($urandom);
    s.px = pos_t'($urandom);
    s.py = pos_t'($urandom);
    s.pz = pos_t'($urandom);
    s.ca = IDX_W'($urandom);
    s.cb = IDX_W'($urandom);
    s.cc = IDX_W'($urandom);
    s.cd = IDX_W'($urandom);
    s.quad = 1'($urandom);
    s.fid = ID_W'($urandom);
    s.drain = 0;
    return s;
  endfunction

  function automatic void add_load(int idx, int x, int y, int z);
    stim_t s;
    s = base_item(OP_LOAD);
    s.vi = IDX_W'(idx);
    s.px = pos_t'(x);
    s.py = pos_t'(y);
    s.pz = pos_t'(z);
    pending_items.push_back(s);
    loaded.push_back(idx);
  endfunction

  function automatic void add_face(int a, int b, int c, int d, bit q, int id);
    stim_t s;
    s = base_item(OP_FACE);
    s.ca = IDX_W'(a);
    s.cb = IDX_W'(b);
    s.cc = IDX_W'(c);
    s.cd = IDX_W'(d);
    s.quad = q;
    s.fid = ID_W'(id);
    pending_items.push_back(s);
  endfunction

  function automatic void add_read(int idx, bit dr);
    stim_t s;
    s = base_item(OP_READ);
    s.vi = IDX_W'(idx);
    s.drain = dr;
    pending_items.push_back(s);
  endfunction

  initial begin
    stim_t s;
    int r, lo;
    for (int i = 0; i < 1024; i++) begin
      cnt_tab[i] = 0;
      for (int j = 0; j < 3; j++) begin
        pos_tab[i][j] = 0;
        sum_tab[i][j] = 0;
      end
    end
    // extreme corners, a unit triangle, a zero-area face and a never-faced read
    add_load(0, -32768, -32768, -32768);
    add_load(1, 32767, -32768, 32767);
    add_load(2, 32767, 32767, -32768);
    add_load(1023, 0, 1, 0);
    add_load(3, 1, 0, 0);
    add_load(4, 0, 0, 0);
    add_face(0, 1, 2, 1023, 1, 16'hFFFF);
    add_face(4, 3, 1023, 0, 0, 0);
    add_face(3, 3, 1023, 5, 0, 1);
    add_read(0, 0);
    add_read(1023, 0);
    add_read(512, 0);
    s = base_item(OP_NONE);
    pending_items.push_back(s);
    add_read(4, 0);
    add_face(1023, 4, 3, 0, 1, 16'h8000);
    add_read(3, 0);
    add_read(2, 1);

    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        lo = $urandom_range(0, 1);
        if (lo)
          add_load($urandom_range(0, 1023), $urandom, $urandom, $urandom);
        else
          add_load(loaded[$urandom_range(0, loaded.size() - 1)], $urandom_range(0, 100) - 50,
                   $urandom_range(0, 100) - 50, $urandom_range(0, 100) - 50);
      end else if (r < 62) begin
        add_face(loaded[$urandom_range(0, loaded.size() - 1)],
                 loaded[$urandom_range(0, loaded.size() - 1)],
                 loaded[$urandom_range(0, loaded.size() - 1)],
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                             : loaded[$urandom_range(0, loaded.size() - 1)],
                 1'($urandom_range(0, 1)), $urandom);
      end else if (r < 95) begin
        add_read(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                             : loaded[$urandom_range(0, loaded.size() - 1)],
                 n == 400);
      end else begin
        s = base_item(OP_NONE);
        pending_items.push_back(s);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_items.size() != 0 || have_nxt || in_valid || expected_normals.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
